// ===== hdl/trdt_pkg.sv =====
// ----------------------------------------------------------------------------
// trdt_pkg
// Shared constants and types for the transaction reservation table.
// ----------------------------------------------------------------------------
package trdt_pkg;

  localparam int NUM_TABLES_DEF      = 8;
  localparam int SLOTS_PER_TABLE_DEF = 4096;
  localparam int STAMP_WIDTH_DEF     = 32;

  localparam int TABLE_W   = 3;
  localparam int SLOT_W    = 12;
  localparam int TXN_W     = 32;
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;

  localparam logic ACT_RESERVE = 1'b0;
  localparam logic ACT_ANALYSE = 1'b1;

  typedef struct packed {
    logic raw;
    logic war;
    logic waw;
  } flags_t;

endpackage

// ===== hdl/trdt_stamp_ram.sv =====
// ----------------------------------------------------------------------------
// trdt_stamp_ram
// Simple dual-port stamp memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module trdt_stamp_ram #(
  parameter int DEPTH  = trdt_pkg::NUM_TABLES_DEF * trdt_pkg::SLOTS_PER_TABLE_DEF,
  parameter int DATA_W = trdt_pkg::STAMP_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/txn_reserve_dependency_table_core.sv =====
// ----------------------------------------------------------------------------
// txn_reserve_dependency_table_core
// Read and write stamp stores with minimum-ID reservation and conflict
// analysis over a transaction's read/write set.
// A taken transaction passes through ST_EXEC and its result is then held in
// the output register. The next is taken only in ST_IDLE with that register
// free or draining, after the stamp memories' read-then-write (read in the
// accept cycle, update in the next). Reset: a clearing pass zeroes, one a cycle,
// all NUM_TABLES*SLOTS_PER_TABLE entries (32768 by default), s_axis_tready low.
// ----------------------------------------------------------------------------
module txn_reserve_dependency_table_core #(
  parameter int NUM_TABLES      = trdt_pkg::NUM_TABLES_DEF,
  parameter int SLOTS_PER_TABLE = trdt_pkg::SLOTS_PER_TABLE_DEF,
  parameter int STAMP_WIDTH     = trdt_pkg::STAMP_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] table_index, [14:3] key_slot, [46:15] txn_id, [47] zero
  input  logic [trdt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] action, [1] is_write
  input  logic [trdt_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] waw, [1] war, [2] raw, [7:3] zero
  output logic [trdt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int DEPTH  = NUM_TABLES * SLOTS_PER_TABLE;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  logic                         act_q, wr_q, hit_q, last_q;
  logic [ADDR_W-1:0]            addr_q;
  logic [STAMP_WIDTH-1:0]       id_q;
  trdt_pkg::flags_t             flags_q, flags_d, flags_new;

  logic                         m_valid_q, m_valid_d;
  trdt_pkg::flags_t             m_flags_q;
  logic                         m_last_q;

  logic [trdt_pkg::TABLE_W-1:0] in_table;
  logic [trdt_pkg::SLOT_W-1:0]  in_slot;
  logic [trdt_pkg::TXN_W-1:0]   in_txn;
  logic                         in_hit;
  logic [ADDR_W-1:0]            in_addr;
  logic                         accept;

  logic                         we_r, we_w;
  logic [ADDR_W-1:0]            waddr;
  logic [STAMP_WIDTH-1:0]       wdata;
  logic [STAMP_WIDTH-1:0]       rd_r, rd_w;
  logic                         r_earlier, w_earlier, r_lower, w_lower;

  assign in_table = s_axis_tdata[trdt_pkg::TABLE_W-1:0];
  assign in_slot  = s_axis_tdata[trdt_pkg::TABLE_W +: trdt_pkg::SLOT_W];
  assign in_txn   = s_axis_tdata[trdt_pkg::TABLE_W + trdt_pkg::SLOT_W +: trdt_pkg::TXN_W];
  assign in_hit   = (32'(in_table) < 32'(NUM_TABLES)) && (32'(in_slot) < 32'(SLOTS_PER_TABLE));
  assign in_addr  = ADDR_W'(in_table) * ADDR_W'(SLOTS_PER_TABLE) + ADDR_W'(in_slot);

  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign r_earlier = (rd_r != '0) && (rd_r < id_q);
  assign w_earlier = (rd_w != '0) && (rd_w < id_q);
  assign r_lower   = (rd_r == '0) || (rd_r > id_q);
  assign w_lower   = (rd_w == '0) || (rd_w > id_q);

  always_comb begin
    flags_new = flags_q;
    if (act_q == trdt_pkg::ACT_ANALYSE && hit_q) begin
      if (wr_q) begin
        flags_new.waw = flags_q.waw | w_earlier;
        flags_new.war = flags_q.war | r_earlier;
      end else begin
        flags_new.raw = flags_q.raw | w_earlier;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    flags_d   = flags_q;
    m_valid_d = m_valid_q;
    we_r      = 1'b0;
    we_w      = 1'b0;
    waddr     = addr_q;
    wdata     = id_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        we_r  = 1'b1;
        we_w  = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (act_q == trdt_pkg::ACT_RESERVE && hit_q) begin
          we_w = wr_q && w_lower;
          we_r = !wr_q && r_lower;
        end
        flags_d   = last_q ? '0 : flags_new;
        m_valid_d = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      flags_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      flags_q   <= flags_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= s_axis_tuser[0];
      wr_q   <= s_axis_tuser[1];
      hit_q  <= in_hit;
      last_q <= s_axis_tlast;
      addr_q <= in_addr;
      id_q   <= STAMP_WIDTH'(in_txn);
    end
    if (state_q == ST_EXEC) begin
      m_flags_q <= flags_new;
      m_last_q  <= last_q;
    end
  end

  trdt_stamp_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (STAMP_WIDTH)
  ) u_read_stamps (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (rd_r)
  );

  trdt_stamp_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (STAMP_WIDTH)
  ) u_write_stamps (
    .clk_i   (clk_i),
    .we_i    (we_w),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (rd_w)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = trdt_pkg::M_TDATA_W'({m_flags_q.raw, m_flags_q.war, m_flags_q.waw});
  assign m_axis_tlast  = m_last_q;

endmodule
